// ===== rtl/sal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sal_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int FIELD_BITS    = 64;
  localparam int IN_DATA_BITS  = 136;
  localparam int OUT_DATA_BITS = 72;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRIV    = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;
  localparam logic [1:0] ST_DIVOVF  = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/sal_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sal_mul #(
  parameter int WORD_BITS = sal_pkg::WORD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic [2:0]               en,
  input  wire logic [WORD_BITS-1:0]     mag_a,
  input  wire logic [WORD_BITS-1:0]     mag_b,
  output logic      [2*WORD_BITS-1:0]   prod
);
  import sal_pkg::*;

  localparam int LO = WORD_BITS / 2;
  localparam int HI = WORD_BITS - LO;
  localparam int PW = 2 * WORD_BITS;

  logic [2*LO-1:0]  ll;
  logic [LO+HI-1:0] lh;
  logic [LO+HI-1:0] hl;
  logic [2*HI-1:0]  hh;
  logic [PW-1:0]    part_lo;
  logic [PW-1:0]    part_hi;

  // four half-width products, then pairwise sums, then the full product
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ll <= mag_a[LO-1:0] * mag_b[LO-1:0];
      lh <= mag_a[LO-1:0] * mag_b[WORD_BITS-1:LO];
      hl <= mag_a[WORD_BITS-1:LO] * mag_b[LO-1:0];
      hh <= mag_a[WORD_BITS-1:LO] * mag_b[WORD_BITS-1:LO];
    end
    if (en[1]) begin
      part_lo <= PW'(ll) + (PW'(lh) << LO);
      part_hi <= (PW'(hl) << LO) + (PW'(hh) << (2 * LO));
    end
    if (en[2]) begin
      prod <= part_lo + part_hi;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sal_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sal_div #(
  parameter int WORD_BITS = sal_pkg::WORD_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic [WORD_BITS-1:0]   en,
  input  wire logic [WORD_BITS-1:0]   mag_a,
  input  wire logic [WORD_BITS-1:0]   mag_b,
  output logic      [WORD_BITS-1:0]   quot
);
  import sal_pkg::*;

  logic [WORD_BITS-1:0] rem  [WORD_BITS];
  logic [WORD_BITS-1:0] quo  [WORD_BITS];
  logic [WORD_BITS-1:0] dvsr [WORD_BITS];

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < WORD_BITS; j++) begin : g_step
    logic [WORD_BITS-1:0] rem_in;
    logic [WORD_BITS-1:0] quo_in;
    logic [WORD_BITS-1:0] dvsr_in;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = mag_a;
      assign dvsr_in = mag_b;
    end else begin : g_next
      assign rem_in  = rem[j-1];
      assign quo_in  = quo[j-1];
      assign dvsr_in = dvsr[j-1];
    end

    assign trial = {rem_in, quo_in[WORD_BITS-1]};
    assign diff  = trial - {1'b0, dvsr_in};

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j]  <= diff[WORD_BITS] ? trial[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
        quo[j]  <= {quo_in[WORD_BITS-2:0], ~diff[WORD_BITS]};
        dvsr[j] <= dvsr_in;
      end
    end
  end

  assign quot = quo[WORD_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/signed_alu_with_flags.sv =====
// channel   | dir | width        | content
// s_axis    | in  | tdata 136    | dest_value, src_value, dest_is_status, supervisor
//           |     | tuser 3      | req_type
// m_axis    | out | tdata 72     | result_value, flags, overflow_updated, status
//
// the pipeline depth is set by the divider's one-bit-per-stage chain; a new beat
// is taken every cycle unless an output stall has backed up to the input.
// rst is synchronous and empties the pipeline.
// a stalled output holds its beat; bubbles ahead of it still close up, so input
// keeps flowing until every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module signed_alu_with_flags #(
  parameter int WORD_BITS = sal_pkg::WORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [63:0] dest_value, [127:64] src_value, [128] dest_is_status, [129] supervisor
  input  wire logic [sal_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // [2:0] req_type
  input  wire logic [2:0]                          s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [63:0] result_value, [64] flag_overflow, [65] overflow_updated,
  // [66] flag_zero, [67] flag_negative, [69:68] status
  output logic      [sal_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
  import sal_pkg::*;

  localparam int N     = WORD_BITS + 4;
  localparam int MUL_K = 5;
  localparam int DIV_K = WORD_BITS + 2;
  localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic [2:0]           op;
    logic [1:0]           st;
    logic                 sgn;
    logic [WORD_BITS-1:0] res;
    logic                 ov;
    logic                 upd;
    logic                 zf;
    logic                 nf;
  } ctl_t;

  logic [N-1:0] v;
  logic [N-1:0] en;

  logic [2:0]           s0_op;
  logic [1:0]           s0_st;
  logic [WORD_BITS-1:0] s0_a;
  logic [WORD_BITS-1:0] s0_b;
  logic [WORD_BITS-1:0] mag_a;
  logic [WORD_BITS-1:0] mag_b;

  ctl_t pipe [1:N-1];
  ctl_t s1_next;

  logic [WORD_BITS-1:0]   in_a;
  logic [WORD_BITS-1:0]   in_b;
  logic [1:0]             in_st;
  logic [2*WORD_BITS-1:0] prod;
  logic [WORD_BITS-1:0]   quot;

  // a stage moves when it is empty or the one after it moves
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end
  assign en[N-1] = ~v[N-1] | m_axis_tready;

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= s_axis_tvalid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: take operands apart and settle the status code
  assign in_a = s_axis_tdata[WORD_BITS-1:0];
  assign in_b = s_axis_tdata[FIELD_BITS+WORD_BITS-1:FIELD_BITS];

  always_comb begin
    in_st = ST_OK;
    if (s_axis_tuser > OP_NEG) begin
      in_st = ST_OK;
    end else if (s_axis_tdata[128] && !s_axis_tdata[129]) begin
      in_st = ST_PRIV;
    end else if (s_axis_tuser == OP_DIV && in_b == '0) begin
      in_st = ST_DIVZERO;
    end else if (s_axis_tuser == OP_DIV && in_a == W_MIN && in_b == '1) begin
      in_st = ST_DIVOVF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_op <= s_axis_tuser;
      s0_st <= in_st;
      s0_a  <= in_a;
      s0_b  <= in_b;
    end
  end

  // stage 1: magnitudes for mul and div, add, sub and neg done here
  always_comb begin
    s1_next     = '0;
    s1_next.op  = s0_op;
    s1_next.st  = s0_st;
    s1_next.sgn = s0_a[WORD_BITS-1] ^ s0_b[WORD_BITS-1];
    case (s0_op)
      OP_ADD: begin
        s1_next.res = s0_a + s0_b;
        s1_next.ov  = (s0_a[WORD_BITS-1] == s0_b[WORD_BITS-1])
                   && (s1_next.res[WORD_BITS-1] != s0_a[WORD_BITS-1]);
        s1_next.upd = 1'b1;
      end
      OP_SUB: begin
        s1_next.res = s0_a - s0_b;
        s1_next.ov  = (s0_a[WORD_BITS-1] != s0_b[WORD_BITS-1])
                   && (s1_next.res[WORD_BITS-1] != s0_a[WORD_BITS-1]);
        s1_next.upd = 1'b1;
      end
      OP_MUL: s1_next.upd = 1'b1;
      OP_DIV: s1_next.upd = 1'b0;
      OP_NEG: begin
        s1_next.res = '0 - s0_a;
        s1_next.ov  = (s0_a == W_MIN);
        s1_next.upd = 1'b1;
      end
      default: s1_next.res = s0_a;
    endcase
    if (s0_st != ST_OK) begin
      s1_next.res = '0;
      s1_next.ov  = 1'b0;
      s1_next.upd = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pipe[1] <= s1_next;
      mag_a   <= s0_a[WORD_BITS-1] ? ('0 - s0_a) : s0_a;
      mag_b   <= s0_b[WORD_BITS-1] ? ('0 - s0_b) : s0_b;
    end
  end

  sal_mul #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk   (clk),
    .en    (en[4:2]),
    .mag_a (mag_a),
    .mag_b (mag_b),
    .prod  (prod)
  );

  sal_div #(.WORD_BITS(WORD_BITS)) u_div (
    .clk   (clk),
    .en    (en[WORD_BITS+1:2]),
    .mag_a (mag_a),
    .mag_b (mag_b),
    .quot  (quot)
  );

  for (genvar k = 2; k < N; k++) begin : g_stage
    ctl_t nxt;
    always_comb begin
      nxt = pipe[k-1];
      if (k == MUL_K) begin
        if (nxt.op == OP_MUL && nxt.st == ST_OK) begin
          nxt.res = nxt.sgn ? ('0 - prod[WORD_BITS-1:0]) : prod[WORD_BITS-1:0];
          nxt.ov  = (prod[2*WORD_BITS-1:WORD_BITS] != '0)
                 || (prod[WORD_BITS-1:0] > (nxt.sgn ? W_MIN : W_MAX));
        end
      end
      if (k == DIV_K) begin
        if (nxt.op == OP_DIV && nxt.st == ST_OK) begin
          nxt.res = nxt.sgn ? ('0 - quot) : quot;
        end
      end
      if (k == N - 1) begin
        nxt.zf = (nxt.st == ST_OK) && (nxt.op <= OP_NEG) && (nxt.res == '0);
        nxt.nf = (nxt.st == ST_OK) && (nxt.op <= OP_NEG) && nxt.res[WORD_BITS-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en[k]) pipe[k] <= nxt;
    end
  end

  assign m_axis_tdata = {2'b00, pipe[N-1].st, pipe[N-1].nf, pipe[N-1].zf,
                         pipe[N-1].upd, pipe[N-1].ov,
                         FIELD_BITS'($signed(pipe[N-1].res))};

`ifndef SYNTH
  a_fault_clears: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && pipe[N-1].st != ST_OK) |-> (m_axis_tdata[67:0] == '0))
    else $error("faulted beat carries a result");

  a_ov_needs_upd: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && pipe[N-1].ov) |-> pipe[N-1].upd)
    else $error("overflow set without update");

  a_div_no_upd: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && pipe[N-1].op == OP_DIV) |-> !pipe[N-1].upd)
    else $error("division wrote overflow");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid straight after reset");
`endif

endmodule

`default_nettype wire
